[hdl/rvde_pkg.sv]
// Package with opcode codes, the decoded and result types and the upper mask.
`default_nettype none
package rvde_pkg;

   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

   // Instruction classes, one-hot.
   localparam int unsigned NUM_CLASS = 10;
   localparam int unsigned C_OPIMM  = 0;
   localparam int unsigned C_OP     = 1;
   localparam int unsigned C_LOAD   = 2;
   localparam int unsigned C_STORE  = 3;
   localparam int unsigned C_BRANCH = 4;
   localparam int unsigned C_JAL    = 5;
   localparam int unsigned C_JALR   = 6;
   localparam int unsigned C_LUI    = 7;
   localparam int unsigned C_AUIPC  = 8;
   localparam int unsigned C_SYSTEM = 9;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // Queue between front and back.
   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QIDX_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // One classified instruction as it travels from front to back.
   typedef struct packed {
      logic [NUM_CLASS-1:0] cls;
      logic [2:0]           funct3;
      logic                 alt;
      logic [4:0]           rd;
      logic [31:0]          imm;
      logic [31:0]          pc;
      logic [31:0]          rs1;
      logic [31:0]          rs2;
   } decoded_type;

   typedef struct packed {
      logic [4:0]  dest_reg;
      logic        write_enable;
      logic [31:0] result_value;
      logic        redirect;
      logic [31:0] next_pc;
      logic        mem_read;
      logic        mem_write;
      logic [31:0] mem_address;
      logic [31:0] store_data;
      logic [2:0]  access_kind;
      logic        halt;
   } result_type;

endpackage
`default_nettype wire

[hdl/rvde_front.sv]
// Front part: classifies each instruction and builds its immediate.
`default_nettype none
module rvde_front import rvde_pkg::*; (
   input  wire logic [31:0] instruction,
   input  wire logic [31:0] pc_value,
   input  wire logic [31:0] rs1_value,
   input  wire logic [31:0] rs2_value,
   output decoded_type      decoded
);

   logic [6:0]  opcode;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

   assign opcode = instruction[6:0];
   assign imm_i  = {{20{instruction[31]}}, instruction[31:20]};
   assign imm_s  = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
   assign imm_b  = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                    instruction[11:8], 1'b0};
   assign imm_j  = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                    instruction[30:21], 1'b0};
   assign imm_u  = instruction & UPPER_MASK;

   always_comb begin
      decoded        = '0;
      decoded.funct3 = instruction[14:12];
      decoded.alt    = instruction[30];
      decoded.rd     = instruction[11:7];
      decoded.pc     = pc_value;
      decoded.rs1    = rs1_value;
      decoded.rs2    = rs2_value;
      decoded.imm    = imm_i;
      case (opcode)
         OPC_OPIMM:  decoded.cls[C_OPIMM] = 1'b1;
         OPC_OP:     decoded.cls[C_OP] = 1'b1;
         OPC_LOAD:   decoded.cls[C_LOAD] = 1'b1;
         OPC_JALR:   decoded.cls[C_JALR] = 1'b1;
         OPC_SYSTEM: decoded.cls[C_SYSTEM] = 1'b1;
         OPC_STORE: begin
            decoded.cls[C_STORE] = 1'b1;
            decoded.imm = imm_s;
         end
         OPC_BRANCH: begin
            decoded.cls[C_BRANCH] = 1'b1;
            decoded.imm = imm_b;
         end
         OPC_JAL: begin
            decoded.cls[C_JAL] = 1'b1;
            decoded.imm = imm_j;
         end
         OPC_LUI: begin
            decoded.cls[C_LUI] = 1'b1;
            decoded.imm = imm_u;
         end
         OPC_AUIPC: begin
            decoded.cls[C_AUIPC] = 1'b1;
            decoded.imm = imm_u;
         end
         default: decoded.cls = '0;
      endcase
   end

endmodule
`default_nettype wire

[hdl/rvde_queue.sv]
// Small register queue used between the front and the back.
`default_nettype none
module rvde_queue import rvde_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire decoded_type push_data,
   output logic             full,
   input  wire logic        pop,
   output decoded_type      pop_data,
   output logic             empty
);

   decoded_type             mem_ff [QDEPTH];
   logic [QIDX_W-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH)) else $error("queue count overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");
   a_ptrs_meet: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

[hdl/rvde_back.sv]
// Back part: executes one classified instruction into a registered result.
`default_nettype none
module rvde_back import rvde_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire decoded_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output result_type       out_data,
   input  wire logic        out_ready
);

   result_type  res_ff, res_in;
   logic        valid_ff, valid_in;
   logic [31:0] a, b, alu, sum_ab, sum_imm, pc4, tgt;
   logic [4:0]  sh;
   logic        eq, lt_u, lt_s, take;
   logic        is_reg;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = res_ff;

   always_comb begin
      is_reg  = in_data.cls[C_OP];
      a       = in_data.rs1;
      b       = is_reg ? in_data.rs2 : in_data.imm;
      sh      = b[4:0];
      sum_ab  = (is_reg && in_data.alt) ? a - b : a + b;
      sum_imm = in_data.rs1 + in_data.imm;
      pc4     = in_data.pc + 32'd4;
      tgt     = in_data.pc + in_data.imm;
      eq      = (in_data.rs1 == in_data.rs2);
      lt_u    = (in_data.rs1 < in_data.rs2);
      lt_s    = ($signed(in_data.rs1) < $signed(in_data.rs2));
      case (in_data.funct3)
         F3_ADD:  alu = sum_ab;
         F3_SLL:  alu = a << sh;
         F3_SLT:  alu = {31'd0, $signed(a) < $signed(b)};
         F3_SLTU: alu = {31'd0, a < b};
         F3_XOR:  alu = a ^ b;
         F3_SR:   alu = in_data.alt ? 32'($signed(a) >>> sh) : a >> sh;
         F3_OR:   alu = a | b;
         default: alu = a & b;
      endcase
      case (in_data.funct3)
         F3_BEQ:  take = eq;
         F3_BNE:  take = !eq;
         F3_BLT:  take = lt_s;
         F3_BGE:  take = !lt_s;
         F3_BLTU: take = lt_u;
         F3_BGEU: take = !lt_u;
         default: take = 1'b0;
      endcase

      res_in          = '0;
      res_in.dest_reg = in_data.rd;
      res_in.next_pc  = pc4;
      res_in.halt     = in_data.cls[C_SYSTEM];
      if (in_data.cls[C_OPIMM] || in_data.cls[C_OP]) begin
         res_in.result_value = alu;
      end
      if (in_data.cls[C_LUI]) begin
         res_in.result_value = in_data.imm;
      end
      if (in_data.cls[C_AUIPC]) begin
         res_in.result_value = tgt;
      end
      if (in_data.cls[C_JAL] || in_data.cls[C_JALR]) begin
         res_in.result_value = pc4;
         res_in.redirect     = 1'b1;
         res_in.next_pc      = in_data.cls[C_JAL] ? tgt : {sum_imm[31:1], 1'b0};
      end
      if (in_data.cls[C_BRANCH] && take) begin
         res_in.redirect = 1'b1;
         res_in.next_pc  = tgt;
      end
      if (in_data.cls[C_LOAD] || in_data.cls[C_STORE]) begin
         res_in.mem_read    = in_data.cls[C_LOAD];
         res_in.mem_write   = in_data.cls[C_STORE];
         res_in.mem_address = sum_imm;
         res_in.access_kind = in_data.funct3;
         res_in.store_data  = in_data.cls[C_STORE] ? in_data.rs2 : 32'd0;
      end
      res_in.write_enable = (in_data.rd != 5'd0) &&
         (in_data.cls[C_OPIMM] || in_data.cls[C_OP] || in_data.cls[C_LOAD] ||
          in_data.cls[C_LUI] || in_data.cls[C_AUIPC] || in_data.cls[C_JAL] ||
          in_data.cls[C_JALR]);

      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         res_ff <= res_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(res_ff)))
      else $error("stalled result changed");
   a_we_rd: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(res_ff.write_enable && res_ff.dest_reg == 5'd0))
      else $error("write enable with x0");
   a_mem_excl: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(res_ff.mem_read && res_ff.mem_write))
      else $error("load and store at once");

endmodule
`default_nettype wire

[hdl/rv32i_decode_execute.sv]
// Top level of the RV32I decode and execute unit.
//
// The block takes one RV32I instruction with its pc and both source register values
// on the request side and returns one result for each, in order, on the response side.
// Both sides look like a queue. A request transfer happens at a clock edge with
// req_push high and req_full low; a response transfer happens at an edge with rsp_pop
// high and rsp_empty low, and the oldest result is shown on the rsp_ ports while
// rsp_empty is low.
// The front decodes the opcode and builds the immediate in the request cycle and
// writes the classified instruction into a two-entry queue. The back reads that queue,
// runs the ALU, branch compare and address adders and registers the result, so a result
// passes through a queue entry and then the result register after its request transfer.
// One instruction per cycle is sustained while the receiver pops every result.
// When the receiver stalls, the result register holds, the queue fills and req_full
// rises once two instructions wait in the queue; nothing is lost. Reset empties the
// queue and the result register.
`default_nettype none
module rv32i_decode_execute import rvde_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [31:0] req_instruction,
   input  wire logic [31:0] req_pc_value,
   input  wire logic [31:0] req_rs1_value,
   input  wire logic [31:0] req_rs2_value,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [4:0]       rsp_dest_reg,
   output logic             rsp_write_enable,
   output logic [31:0]      rsp_result_value,
   output logic             rsp_redirect,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_mem_read,
   output logic             rsp_mem_write,
   output logic [31:0]      rsp_mem_address,
   output logic [31:0]      rsp_store_data,
   output logic [2:0]       rsp_access_kind,
   output logic             rsp_halt
);

   decoded_type front_data, queue_data;
   result_type  result;
   logic        queue_empty, back_ready, back_valid;

   // Front: pure decode in the request cycle.
   rvde_front u_front (
      .instruction (req_instruction),
      .pc_value    (req_pc_value),
      .rs1_value   (req_rs1_value),
      .rs2_value   (req_rs2_value),
      .decoded     (front_data)
   );

   // The queue decouples decode from execute.
   rvde_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_data),
      .full      (req_full),
      .pop       (back_ready),
      .pop_data  (queue_data),
      .empty     (queue_empty)
   );

   // Back: execute and hold the result until it is popped.
   rvde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!queue_empty),
      .in_data   (queue_data),
      .in_ready  (back_ready),
      .out_valid (back_valid),
      .out_data  (result),
      .out_ready (rsp_pop)
   );

   assign rsp_empty        = !back_valid;
   assign rsp_dest_reg     = result.dest_reg;
   assign rsp_write_enable = result.write_enable;
   assign rsp_result_value = result.result_value;
   assign rsp_redirect     = result.redirect;
   assign rsp_next_pc      = result.next_pc;
   assign rsp_mem_read     = result.mem_read;
   assign rsp_mem_write    = result.mem_write;
   assign rsp_mem_address  = result.mem_address;
   assign rsp_store_data   = result.store_data;
   assign rsp_access_kind  = result.access_kind;
   assign rsp_halt         = result.halt;

endmodule
`default_nettype wire

[bench/rvde_checker.sv]
// Checker that watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
module rvde_checker import rvde_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic [31:0] req_instruction,
   input  wire logic [31:0] req_pc_value,
   input  wire logic [31:0] req_rs1_value,
   input  wire logic [31:0] req_rs2_value,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic [4:0]  rsp_dest_reg,
   input  wire logic        rsp_write_enable,
   input  wire logic [31:0] rsp_result_value,
   input  wire logic        rsp_redirect,
   input  wire logic [31:0] rsp_next_pc,
   input  wire logic        rsp_mem_read,
   input  wire logic        rsp_mem_write,
   input  wire logic [31:0] rsp_mem_address,
   input  wire logic [31:0] rsp_store_data,
   input  wire logic [2:0]  rsp_access_kind,
   input  wire logic        rsp_halt,
   output int               fail_count,
   output int               pending_count
);

   result_type exec_results[$];

   function automatic logic [31:0] sext_i(logic [31:0] w);
      return {{20{w[31]}}, w[31:20]};
   endfunction

   function automatic logic [31:0] run_alu(logic [2:0] f3, logic alt, logic is_reg,
                                           logic [31:0] a, logic [31:0] b);
      logic [4:0] sh;
      sh = b[4:0];
      case (f3)
         F3_ADD:  return (is_reg && alt) ? a - b : a + b;
         F3_SLL:  return a << sh;
         F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
         F3_SLTU: return {31'd0, a < b};
         F3_XOR:  return a ^ b;
         F3_SR:   return alt ? 32'($signed(a) >>> sh) : a >> sh;
         F3_OR:   return a | b;
         default: return a & b;
      endcase
   endfunction

   function automatic result_type execute_instr(logic [31:0] w, logic [31:0] pc,
                                                logic [31:0] r1, logic [31:0] r2);
      result_type r;
      logic writes, take;
      logic [31:0] imm_s, imm_b, imm_j;
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      r = '0;
      writes = 1'b0;
      take = 1'b0;
      r.dest_reg = w[11:7];
      r.next_pc = pc + 32'd4;
      case (w[6:0])
         OPC_OPIMM: begin
            writes = 1'b1;
            r.result_value = run_alu(w[14:12], w[30], 1'b0, r1, sext_i(w));
         end
         OPC_OP: begin
            writes = 1'b1;
            r.result_value = run_alu(w[14:12], w[30], 1'b1, r1, r2);
         end
         OPC_LUI: begin
            writes = 1'b1;
            r.result_value = w & UPPER_MASK;
         end
         OPC_AUIPC: begin
            writes = 1'b1;
            r.result_value = pc + (w & UPPER_MASK);
         end
         OPC_JAL: begin
            writes = 1'b1;
            r.result_value = pc + 32'd4;
            r.redirect = 1'b1;
            r.next_pc = pc + imm_j;
         end
         OPC_JALR: begin
            writes = 1'b1;
            r.result_value = pc + 32'd4;
            r.redirect = 1'b1;
            r.next_pc = (r1 + sext_i(w)) & ~32'd1;
         end
         OPC_LOAD: begin
            writes = 1'b1;
            r.mem_read = 1'b1;
            r.mem_address = r1 + sext_i(w);
            r.access_kind = w[14:12];
         end
         OPC_STORE: begin
            r.mem_write = 1'b1;
            r.mem_address = r1 + imm_s;
            r.store_data = r2;
            r.access_kind = w[14:12];
         end
         OPC_BRANCH: begin
            case (w[14:12])
               F3_BEQ:  take = r1 == r2;
               F3_BNE:  take = r1 != r2;
               F3_BLT:  take = $signed(r1) < $signed(r2);
               F3_BGE:  take = $signed(r1) >= $signed(r2);
               F3_BLTU: take = r1 < r2;
               F3_BGEU: take = r1 >= r2;
               default: take = 1'b0;
            endcase
            if (take) begin
               r.redirect = 1'b1;
               r.next_pc = pc + imm_b;
            end
         end
         OPC_SYSTEM: r.halt = 1'b1;
         default: ;
      endcase
      r.write_enable = writes && (w[11:7] != 5'd0);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending_count = exec_results.size();

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_push && !req_full)
            exec_results.push_back(execute_instr(req_instruction, req_pc_value,
                                                 req_rs1_value, req_rs2_value));
         if (rsp_pop && !rsp_empty) begin
            if (exec_results.size() == 0) begin
               report_mismatch("unexpected transfer", 0, 0);
            end else begin
               want = exec_results.pop_front();
               if (rsp_dest_reg !== want.dest_reg)
                  report_mismatch("dest_reg", rsp_dest_reg, want.dest_reg);
               if (rsp_write_enable !== want.write_enable)
                  report_mismatch("write_enable", rsp_write_enable, want.write_enable);
               if (rsp_result_value !== want.result_value)
                  report_mismatch("result_value", rsp_result_value, want.result_value);
               if (rsp_redirect !== want.redirect)
                  report_mismatch("redirect", rsp_redirect, want.redirect);
               if (rsp_next_pc !== want.next_pc)
                  report_mismatch("next_pc", rsp_next_pc, want.next_pc);
               if (rsp_mem_read !== want.mem_read)
                  report_mismatch("mem_read", rsp_mem_read, want.mem_read);
               if (rsp_mem_write !== want.mem_write)
                  report_mismatch("mem_write", rsp_mem_write, want.mem_write);
               if (rsp_mem_address !== want.mem_address)
                  report_mismatch("mem_address", rsp_mem_address, want.mem_address);
               if (rsp_store_data !== want.store_data)
                  report_mismatch("store_data", rsp_store_data, want.store_data);
               if (rsp_access_kind !== want.access_kind)
                  report_mismatch("access_kind", rsp_access_kind, want.access_kind);
               if (rsp_halt !== want.halt)
                  report_mismatch("halt", rsp_halt, want.halt);
            end
         end
      end
   end

endmodule

[bench/tb.sv]
// Top of the testbench: clock, reset, instruction stimulus and the final verdict.
`timescale 1ns / 1ps
module tb;
   import rvde_pkg::*;

   // The unit holds state in its queue and result register; the run is a sequence of
   // idling phases over one instruction stream.
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_instruction = '0;
   logic [31:0] req_pc_value = '0;
   logic [31:0] req_rs1_value = '0;
   logic [31:0] req_rs2_value = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [4:0]  rsp_dest_reg;
   logic        rsp_write_enable;
   logic [31:0] rsp_result_value;
   logic        rsp_redirect;
   logic [31:0] rsp_next_pc;
   logic        rsp_mem_read;
   logic        rsp_mem_write;
   logic [31:0] rsp_mem_address;
   logic [31:0] rsp_store_data;
   logic [2:0]  rsp_access_kind;
   logic        rsp_halt;
   int          fail_count;
   int          pending_count;

   // Percent chance per cycle that the sender idles and the receiver stalls.
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   // While set, the receiver holds off completely.
   logic        hold_off = 1'b0;
   int          cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rv32i_decode_execute u_top (.*);

   rvde_checker u_checker (.*);

   // A cycle counter guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The receiver decides pop once per edge, so pop never toggles twice in a step.
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // One request transfer: present the item, then wait for an edge without full.
   task automatic send_instr(logic [31:0] w, logic [31:0] pc, logic [31:0] r1,
                             logic [31:0] r2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_instruction <= w;
      req_pc_value <= pc;
      req_rs1_value <= r1;
      req_rs2_value <= r2;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Operands lean toward the corners so the compares and carries get exercised.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Random instruction: mostly valid opcodes with random fields, some raw noise.
   function automatic logic [31:0] pick_instr();
      logic [6:0] opcodes[10];
      logic [31:0] w;
      opcodes = '{OPC_OPIMM, OPC_OP, OPC_LOAD, OPC_STORE, OPC_BRANCH,
                  OPC_JAL, OPC_JALR, OPC_LUI, OPC_AUIPC, OPC_SYSTEM};
      w = $urandom;
      if ($urandom_range(9) != 0)
         w[6:0] = opcodes[$urandom_range(9)];
      return w;
   endfunction

   task automatic send_random();
      logic [31:0] r1;
      r1 = pick_operand();
      // Equal operands make branch-equal outcomes likely to be taken.
      send_instr(pick_instr(), $urandom, r1,
                 ($urandom_range(3) == 0) ? r1 : pick_operand());
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] pc_top;
      pc_top = 32'hFFFF_FFFC;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every opcode, ALU function and the named special cases.
      send_instr(32'h0000_0000, pc_top, 32'd0, 32'd0);              // all-zero word
      send_instr(32'hFFF0_0093, 32'd0, 32'h7FFF_FFFF, 32'd0);       // addi, imm -1
      send_instr(32'h8000_0013 | (5'd31 << 7), 32'd0, 32'd5, 32'd0); // addi to x31
      send_instr(32'h41F0_D093, 32'd0, 32'h8000_0000, 32'd0);       // srai 31
      send_instr(32'h01F0_D093, 32'd0, 32'h8000_0000, 32'd0);       // srli 31
      send_instr(32'hC000_8033 | (3'd0 << 12), 32'd0, 32'd1, 32'd2); // sub, odd funct7
      send_instr(32'h4000_D0B3, 32'd0, 32'hF000_0000, 32'hFFFF_FFE4); // sra, rs2 low bits
      send_instr(32'h0000_20B3, 32'd0, 32'h8000_0000, 32'd1);       // slt
      send_instr(32'h0000_30B3, 32'd0, 32'h8000_0000, 32'd1);       // sltu
      send_instr(32'h0000_10B3, 32'd0, 32'd1, 32'd33);              // sll
      send_instr(32'h0000_40B3, 32'd0, 32'hAAAA_AAAA, 32'hFFFF_FFFF); // xor
      send_instr(32'h0000_60B3, 32'd0, 32'h1234_0000, 32'h0000_5678); // or
      send_instr(32'h0000_70B3, 32'd0, 32'hFFFF_FFFF, 32'h0F0F_0F0F); // and
      send_instr(32'hFFFF_F0B7, 32'd0, 32'd0, 32'd0);               // lui
      send_instr(32'h8000_0097, pc_top, 32'd0, 32'd0);              // auipc wraps
      send_instr(32'h0000_006F, 32'h100, 32'd0, 32'd0);             // jal to itself
      send_instr(32'h8000_00EF, 32'd0, 32'd0, 32'd0);               // jal, most negative
      send_instr(32'h0010_70E7, 32'h101, 32'h100, 32'd0);           // jalr, funct3 set
      send_instr(32'h7FF0_4083, 32'hFFFF_FFFF, 32'h0, 32'd0);       // load, funct3 4
      send_instr(32'hFE00_FFA3, 32'd0, 32'd0, 32'hDEAD_BEEF);       // store, funct3 7
      send_instr(32'h8000_0063, 32'd0, 32'd3, 32'd3);               // beq taken backward
      send_instr(32'h0000_2063, 32'd0, 32'd3, 32'd3);               // branch funct3 2
      send_instr(32'h7E00_CFE3, pc_top, 32'h8000_0000, 32'd0);      // blt taken
      send_instr(32'h0000_F063, 32'd0, 32'd0, 32'hFFFF_FFFF);       // bgeu not taken
      send_instr(32'hFFFF_FFF3, 32'd0, 32'd0, 32'd0);               // system
      wait_drained();

      // Random phases with different idling mixes.
      repeat (250) send_random();
      send_idle_pct = 61;
      repeat (200) send_random();
      send_idle_pct = 0;
      recv_stall_pct = 61;
      repeat (200) send_random();
      send_idle_pct = 22;
      recv_stall_pct = 22;
      repeat (200) send_random();

      // Sender pauses until every expected result has come.
      wait_drained();

      // Receiver holds off for a long stretch while the sender keeps offering.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off <= 1'b1;
      fork
         begin
            repeat (40) @(posedge clock);
            hold_off <= 1'b0;
         end
         repeat (175) send_random();
      join

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
